FILE: hw/rtl/codel_pkg.sv
// Shared types, constants and helpers for the CoDel queue drop controller.
package codel_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 32;
  localparam int TIME_W = 32;
  localparam int TAG_W = 32;
  localparam int BACKLOG_W = 11;
  localparam int KIND_W = 3;
  localparam int CFG_INDEX_W = 2;

  localparam logic [TIME_W-1:0] TARGET_DELAY_RESET = 32'd5;
  localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd100;
  localparam logic [BACKLOG_W-1:0] MIN_BACKLOG_RESET = 11'd1;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_DELAY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_BACKLOG = 2'd2;

  localparam logic [KIND_W-1:0] KIND_DELIVERED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DROPPED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ENQUEUED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd4;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  // Request to the control-law unit: result = base + isqrt(interval^2 / count)
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] interval;
    logic [31:0]       count;
  } law_req_t;

  function automatic logic at_or_after(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return ~d[TIME_W-1];
  endfunction

endpackage

FILE: hw/rtl/codel_fifo.sv
// Packet FIFO: tag and arrival memories with head/tail pointers and fill count.
module codel_fifo import codel_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic [TIME_W-1:0]                    push_arrival,
  input  logic [TAG_W-1:0]                     push_tag,
  input  logic                                 pop,
  output logic [TIME_W-1:0]                    head_arrival,
  output logic [TAG_W-1:0]                     head_tag,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     occupancy,
  output logic                                 empty,
  output logic                                 full
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH+1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  logic [TIME_W-1:0] arrival_mem [QUEUE_DEPTH];
  logic [TAG_W-1:0]  tag_mem [QUEUE_DEPTH];
  logic [IDX_W-1:0]  head_index;
  logic [IDX_W-1:0]  tail_index;

  assign empty = (occupancy == '0);
  assign full  = (occupancy == OCC_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      arrival_mem[tail_index] <= push_arrival;
      tag_mem[tail_index]     <= push_tag;
    end
    head_arrival <= arrival_mem[head_index];
    head_tag     <= tag_mem[head_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      tail_index <= '0;
      occupancy  <= '0;
    end else begin
      if (push) begin
        tail_index <= (tail_index == LAST_IDX) ? '0 : tail_index + 1'b1;
      end
      if (pop) begin
        head_index <= (head_index == LAST_IDX) ? '0 : head_index + 1'b1;
      end
      if (push && !pop) begin
        occupancy <= occupancy + 1'b1;
      end else if (pop && !push) begin
        occupancy <= occupancy - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/codel_law.sv
// Control-law unit: base + isqrt(interval^2 / count) on one shared subtractor.
module codel_law import codel_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  law_req_t          req,
  output logic              done,
  output logic [TIME_W-1:0] result
);

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_MUL  = 5'b00010,
    L_DIV  = 5'b00100,
    L_SQRT = 5'b01000,
    L_DONE = 5'b10000
  } law_state_t;

  law_state_t        state;
  logic [5:0]        cnt;
  logic [63:0]       acc;
  logic [33:0]       rem;
  logic [31:0]       root;
  logic [31:0]       divisor;
  logic [31:0]       iv;
  logic [TIME_W-1:0] base;

  logic [33:0] sub_a;
  logic [33:0] sub_b;
  logic [34:0] diff;
  logic        ge;

  // One subtractor serves both the divide steps and the square-root steps
  always_comb begin
    if (state == L_SQRT) begin
      sub_a = {rem[31:0], acc[63:62]};
      sub_b = {root, 2'b01};
    end else begin
      sub_a = {1'b0, rem[31:0], acc[63]};
      sub_b = {2'b00, divisor};
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = ~diff[34];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (req.start) begin
            iv      <= req.interval;
            base    <= req.base;
            divisor <= (req.count == '0) ? 32'd1 : req.count;
            state   <= L_MUL;
          end
        end
        L_MUL: begin
          acc   <= 64'(iv) * 64'(iv);
          rem   <= '0;
          cnt   <= '0;
          state <= L_DIV;
        end
        L_DIV: begin
          // restoring divide, one quotient bit a cycle
          rem <= ge ? diff[33:0] : sub_a;
          acc <= {acc[62:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == 6'd63) begin
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= L_SQRT;
          end
        end
        L_SQRT: begin
          // digit-by-digit square root, one root bit a cycle
          rem  <= ge ? diff[33:0] : sub_a;
          root <= {root[30:0], ge};
          acc  <= {acc[61:0], 2'b00};
          cnt  <= cnt + 1'b1;
          if (cnt == 6'd31) begin
            state <= L_DONE;
          end
        end
        L_DONE: begin
          result <= base + root;
          done   <= 1'b1;
          state  <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/codel_queue_drop_control.sv
// CoDel queue: an enqueue item gives one result; a dequeue item pops the head (states
// S_POP and S_POP_DATA for the memory read and judgment), and the first drop and each
// later drop whose next head still qualifies run the control law on an iterative unit of
// one multiply, 64 divide steps and 32 square-root steps, so a dequeue lasts longer when
// many packets drop; the block takes no item meanwhile.
// Results leave through an output register and wait there while stalled.
module codel_queue_drop_control import codel_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   command,
  input  logic [TIME_W-1:0]      now,
  input  logic [TAG_W-1:0]       packet_tag,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [KIND_W-1:0]      kind,
  output logic [TAG_W-1:0]       out_tag,
  output logic [TIME_W-1:0]      sojourn,
  output logic [31:0]            total_drops,
  output logic                   last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH+1);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_POP      = 6'b000010,
    S_POP_DATA = 6'b000100,
    S_AFTER    = 6'b001000,
    S_LAW      = 6'b010000,
    S_LOOP     = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    PH_INIT,
    PH_FIRST,
    PH_LOOP,
    PH_FINAL
  } phase_t;

  state_t state;
  phase_t phase;

  logic [TIME_W-1:0]    target_delay;
  logic [TIME_W-1:0]    interval_ticks;
  logic [BACKLOG_W-1:0] min_backlog;

  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] first_above;
  logic [TIME_W-1:0] next_drop_time;
  logic [31:0]       drop_rate_count;
  logic              in_dropping;
  logic [31:0]       drop_total;
  logic              recent_r;
  logic              law_next_final;

  logic              r_have;
  logic              r_ok;
  logic [TAG_W-1:0]  r_tag;
  logic [TIME_W-1:0] r_soj;

  logic              push;
  logic              pop;
  logic [TIME_W-1:0] head_arrival;
  logic [TAG_W-1:0]  head_tag;
  logic [OCC_W-1:0]  occupancy;
  logic              empty;
  logic              full;

  law_req_t          law_req;
  logic              law_done;
  logic [TIME_W-1:0] law_result;

  logic              out_free;
  logic              accept;
  logic [TIME_W-1:0] soj_now;
  logic [OCC_W-1:0]  occ_after;
  logic              recent;
  logic              window_done;
  logic [31:0]       first_count;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == S_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign push = accept && (command == CMD_ENQUEUE) && !full;
  assign pop  = (state == S_POP_DATA);

  assign soj_now     = now_r - head_arrival;
  assign occ_after   = occupancy - 1'b1;
  assign recent      = (now_r - next_drop_time) < interval_ticks;
  assign window_done = (now_r - first_above) >= interval_ticks;
  assign first_count = !recent_r ? 32'd1 :
                       (drop_rate_count > 32'd2) ? drop_rate_count - 32'd2 : 32'd1;

  always_comb begin
    law_req.start    = 1'b0;
    law_req.base     = next_drop_time;
    law_req.interval = interval_ticks;
    law_req.count    = drop_rate_count;
    if (state == S_AFTER && out_free) begin
      if (phase == PH_FIRST) begin
        law_req.start = 1'b1;
        law_req.base  = now_r;
        law_req.count = first_count;
      end else if (phase == PH_LOOP && r_ok) begin
        law_req.start = 1'b1;
      end
    end
  end

  codel_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_arrival(now),
    .push_tag    (packet_tag),
    .pop         (pop),
    .head_arrival(head_arrival),
    .head_tag    (head_tag),
    .occupancy   (occupancy),
    .empty       (empty),
    .full        (full)
  );

  codel_law u_law (
    .clk   (clk),
    .rst   (rst),
    .req   (law_req),
    .done  (law_done),
    .result(law_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target_delay   <= TARGET_DELAY_RESET;
      interval_ticks <= INTERVAL_RESET;
      min_backlog    <= MIN_BACKLOG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_DELAY: target_delay   <= cfg_data;
        REG_INTERVAL:     interval_ticks <= cfg_data;
        REG_MIN_BACKLOG:  min_backlog    <= cfg_data[BACKLOG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase           <= PH_INIT;
      out_valid       <= 1'b0;
      first_above     <= '0;
      next_drop_time  <= '0;
      drop_rate_count <= '0;
      in_dropping     <= 1'b0;
      drop_total      <= '0;
      recent_r        <= 1'b0;
      law_next_final  <= 1'b0;
      r_have          <= 1'b0;
      r_ok            <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            now_r <= now;
            if (command == CMD_ENQUEUE) begin
              out_valid   <= 1'b1;
              kind        <= full ? KIND_REJECTED : KIND_ENQUEUED;
              out_tag     <= '0;
              sojourn     <= '0;
              total_drops <= drop_total;
              last        <= 1'b1;
            end else if (empty) begin
              first_above <= '0;
              in_dropping <= 1'b0;
              out_valid   <= 1'b1;
              kind        <= KIND_EMPTY;
              out_tag     <= '0;
              sojourn     <= '0;
              total_drops <= drop_total;
              last        <= 1'b1;
            end else begin
              phase <= PH_INIT;
              state <= S_POP;
            end
          end
        end
        S_POP: begin
          // head data shows up in the read register next cycle
          r_ok <= 1'b0;
          if (empty) begin
            r_have      <= 1'b0;
            r_tag       <= '0;
            r_soj       <= '0;
            first_above <= '0;
            state       <= S_AFTER;
          end else begin
            state <= S_POP_DATA;
          end
        end
        S_POP_DATA: begin
          r_have <= 1'b1;
          r_tag  <= head_tag;
          r_soj  <= soj_now;
          if (soj_now < target_delay || 32'(occ_after) < 32'(min_backlog)) begin
            first_above <= '0;
          end else if (first_above == '0) begin
            first_above <= now_r + interval_ticks;
          end else if (at_or_after(now_r, first_above)) begin
            r_ok <= 1'b1;
          end
          state <= S_AFTER;
        end
        S_AFTER: begin
          if (out_free) begin
            case (phase)
              PH_INIT: begin
                if (in_dropping) begin
                  if (!r_ok) begin
                    in_dropping <= 1'b0;
                    phase       <= PH_FINAL;
                  end else begin
                    state <= S_LOOP;
                  end
                end else if (r_ok && (recent || window_done)) begin
                  drop_total  <= drop_total + 1'b1;
                  out_valid   <= 1'b1;
                  kind        <= KIND_DROPPED;
                  out_tag     <= r_tag;
                  sojourn     <= r_soj;
                  total_drops <= drop_total + 1'b1;
                  last        <= 1'b0;
                  recent_r    <= recent;
                  phase       <= PH_FIRST;
                  state       <= S_POP;
                end else begin
                  phase <= PH_FINAL;
                end
              end
              PH_FIRST: begin
                in_dropping     <= 1'b1;
                drop_rate_count <= first_count;
                law_next_final  <= 1'b1;
                state           <= S_LAW;
              end
              PH_LOOP: begin
                if (!r_ok) begin
                  in_dropping <= 1'b0;
                  state       <= S_LOOP;
                end else begin
                  law_next_final <= 1'b0;
                  state          <= S_LAW;
                end
              end
              PH_FINAL: begin
                out_valid   <= 1'b1;
                kind        <= r_have ? KIND_DELIVERED : KIND_EMPTY;
                out_tag     <= r_have ? r_tag : '0;
                sojourn     <= r_have ? r_soj : '0;
                total_drops <= drop_total;
                last        <= 1'b1;
                state       <= S_IDLE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LAW: begin
          if (law_done) begin
            next_drop_time <= law_result;
            if (law_next_final) begin
              phase <= PH_FINAL;
              state <= S_AFTER;
            end else begin
              state <= S_LOOP;
            end
          end
        end
        S_LOOP: begin
          if (out_free) begin
            if (at_or_after(now_r, next_drop_time) && in_dropping) begin
              // drop the current head and judge the next one
              drop_total  <= drop_total + 1'b1;
              out_valid   <= 1'b1;
              kind        <= KIND_DROPPED;
              out_tag     <= r_tag;
              sojourn     <= r_soj;
              total_drops <= drop_total + 1'b1;
              last        <= 1'b0;
              if (drop_rate_count != COUNT_MAX) begin
                drop_rate_count <= drop_rate_count + 1'b1;
              end
              phase <= PH_LOOP;
              state <= S_POP;
            end else begin
              phase <= PH_FINAL;
              state <= S_AFTER;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/codel_queue_drop_control_tb.sv
// Testbench for the CoDel queue drop controller: a random and directed run checked by a scoreboard.
module codel_queue_drop_control_tb import codel_pkg::*; ();

  localparam int DEPTH = DEFAULT_QUEUE_DEPTH;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] soj;
    logic [31:0]       drops;
    logic              last;
  } codel_result_t;

  class codel_scoreboard;
    logic [31:0] arrivals [DEPTH];
    logic [31:0] tags [DEPTH];
    int unsigned head, tail, occ;
    logic [31:0] first_above, next_drop, rate_count, drop_total;
    bit dropping;
    logic [31:0] target, interval;
    logic [10:0] min_backlog;
    codel_result_t pending[$];
    int mismatches;

    function new();
      head = 0; tail = 0; occ = 0;
      first_above = 0; next_drop = 0; rate_count = 0; drop_total = 0;
      dropping = 0;
      target = TARGET_DELAY_RESET; interval = INTERVAL_RESET;
      min_backlog = MIN_BACKLOG_RESET;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_TARGET_DELAY: target = val;
        REG_INTERVAL: interval = val;
        REG_MIN_BACKLOG: min_backlog = val[10:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] next_drop_from(logic [31:0] t);
      logic [63:0] iv, c, lim, lo, hi, mid;
      iv = interval;
      c = (rate_count != 0) ? rate_count : 1;
      lim = (iv * iv) / c;
      lo = 0; hi = iv;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (mid * mid <= lim) lo = mid;
        else hi = mid - 1;
      end
      return t + lo[31:0];
    endfunction

    // Pop head and judge; returns have, sets ok/tag/soj.
    function bit pop_head(logic [31:0] now_t, output bit ok, output logic [31:0] tg,
                          output logic [31:0] sj);
      ok = 0; tg = 0; sj = 0;
      if (occ == 0) begin
        first_above = 0;
        return 0;
      end
      tg = tags[head];
      sj = now_t - arrivals[head];
      head = (head + 1) % DEPTH;
      occ--;
      if (sj < target || occ < min_backlog) first_above = 0;
      else if (first_above == 0) first_above = now_t + interval;
      else if (at_or_after(now_t, first_above)) ok = 1;
      return 1;
    endfunction

    function void push_result(logic [KIND_W-1:0] k, logic [31:0] tg, logic [31:0] sj, bit l);
      codel_result_t r;
      r.kind = k; r.tag = tg; r.soj = sj; r.drops = drop_total; r.last = l;
      pending.push_back(r);
    endfunction

    function void note_item(bit cmd, logic [31:0] now_t, logic [31:0] tg_in);
      bit have, ok, recent;
      logic [31:0] tg, sj;
      if (cmd == CMD_ENQUEUE) begin
        if (occ >= DEPTH) begin
          push_result(KIND_REJECTED, 0, 0, 1);
        end else begin
          arrivals[tail] = now_t;
          tags[tail] = tg_in;
          tail = (tail + 1) % DEPTH;
          occ++;
          push_result(KIND_ENQUEUED, 0, 0, 1);
        end
        return;
      end
      have = pop_head(now_t, ok, tg, sj);
      if (!have) begin
        dropping = 0;
        push_result(KIND_EMPTY, 0, 0, 1);
        return;
      end
      if (dropping) begin
        if (!ok) dropping = 0;
        else begin
          while (at_or_after(now_t, next_drop) && dropping) begin
            drop_total++;
            push_result(KIND_DROPPED, tg, sj, 0);
            if (rate_count != COUNT_MAX) rate_count++;
            have = pop_head(now_t, ok, tg, sj);
            if (!ok) dropping = 0;
            else next_drop = next_drop_from(next_drop);
          end
        end
      end else if (ok && ((now_t - next_drop) < interval || (now_t - first_above) >= interval))
      begin
        recent = (now_t - next_drop) < interval;
        drop_total++;
        push_result(KIND_DROPPED, tg, sj, 0);
        have = pop_head(now_t, ok, tg, sj);
        dropping = 1;
        if (recent) rate_count = (rate_count > 2) ? rate_count - 2 : 1;
        else rate_count = 1;
        next_drop = next_drop_from(now_t);
      end
      if (have) push_result(KIND_DELIVERED, tg, sj, 1);
      else push_result(KIND_EMPTY, 0, 0, 1);
    endfunction

    function void check_result(codel_result_t got);
      codel_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, command = 0;
  logic [31:0] now = 0, packet_tag = 0;
  logic in_stall, out_valid, out_stall = 0, last, cfg_valid = 0, cfg_ready;
  logic [KIND_W-1:0] kind;
  logic [31:0] out_tag, sojourn, total_drops;
  logic [CFG_INDEX_W-1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  int send_idle = 0, recv_stall = 0;
  logic [31:0] clock_now = 0;
  codel_scoreboard sb = new();

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  codel_queue_drop_control u_dut (.*);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{kind, out_tag, sojourn, total_drops, last});
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Valid stays high after the accepting edge until the next item or an idle cycle replaces it.
  task automatic send_item(bit cmd, logic [31:0] t, logic [31:0] tg);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; command <= cmd; now <= t; packet_tag <= tg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(cmd, t, tg);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Enqueue a burst then mostly dequeue, with some enqueues, at growing time: well-formed congestion episode.
  task automatic congestion_run(int n, int step);
    int k, i;
    k = $urandom_range(n);
    for (i = 0; i < k; i++) begin
      clock_now += $urandom_range(3);
      send_item(CMD_ENQUEUE, clock_now, $urandom);
    end
    for (i = 0; i < n - k; i++) begin
      clock_now += $urandom_range(step);
      if ($urandom_range(9) < 7) send_item(CMD_DEQUEUE, clock_now, $urandom);
      else send_item(CMD_ENQUEUE, clock_now, $urandom);
    end
  endtask

  initial begin
    int ph, i;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: empty dequeue, fill past full, extreme tags and times.
    send_item(CMD_DEQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (i = 0; i < 33; i++)
      send_item(CMD_ENQUEUE, i, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom);
    send_item(CMD_DEQUEUE, 32'h8000_0000, 0);
    send_item(CMD_DEQUEUE, 32'h8000_0100, 0);
    drain();
    write_reg(REG_TARGET_DELAY, 0);
    write_reg(REG_INTERVAL, 1);
    write_reg(REG_MIN_BACKLOG, 0);
    clock_now = 32'hFFFF_FFF0;
    congestion_run(40, 4);
    drain();
    write_reg(REG_INTERVAL, 32'hFFFF_FFFF);
    write_reg(REG_TARGET_DELAY, 32'hFFFF_FFFF);
    write_reg(REG_MIN_BACKLOG, 11'h7FF);
    congestion_run(12, 50);
    drain();
    for (ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 72 : 11) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 72 : 11) : 0;
      write_reg(REG_TARGET_DELAY, $urandom_range(8));
      write_reg(REG_INTERVAL, (ph == 0) ? 0 + 3 : $urandom_range(40, 2));
      write_reg(REG_MIN_BACKLOG, $urandom_range(3));
      repeat (3) congestion_run(20, 12);
      drain();
    end
    send_idle = 0; recv_stall = 0;
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("[codel_queue_drop_control] OK");
    else
      $display("[codel_queue_drop_control] ERROR");
    $finish;
  end

  initial begin
    #20000000;
    $display("[codel_queue_drop_control] ERROR");
    $finish;
  end
endmodule
